[rtl/pr5_pkg.sv]
// Shared constants, register codes and types of the five-tap pyramid reduction block.
`default_nettype none

package pr5_pkg;

    // Largest supported input row length in pixels.
    localparam int MAX_WIDTH = 1024;
    // Half the largest row length, and so entries per line of sums.
    localparam int HALF_W    = MAX_WIDTH / 2;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ADDR_W    = $clog2(HALF_W);

    // Fixed widths of the register and data fields.
    localparam int TAP_W     = 16;
    localparam int PIX_W     = 8;
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 12;
    localparam int HSUM_W    = 27;
    localparam int PROD_W    = TAP_W + HSUM_W;
    localparam int VACC_W    = PROD_W + 3;
    localparam int VAL_W     = 8;
    localparam int OROW_W    = 11;
    localparam int OCOL_W    = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int NUM_TAPS  = 5;
    localparam int NUM_LINES = 4;

    // Fractional bits of a vertical sum (two passes of Q1.14).
    localparam int VSCALE    = 28;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TAP_0        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_1        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_2        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_3        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_4        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [TAP_W-1:0]    TAP_0_RESET  = 16'd1024;
    localparam logic [TAP_W-1:0]    TAP_1_RESET  = 16'd4096;
    localparam logic [TAP_W-1:0]    TAP_2_RESET  = 16'd6144;
    localparam logic [TAP_W-1:0]    TAP_3_RESET  = 16'd4096;
    localparam logic [TAP_W-1:0]    TAP_4_RESET  = 16'd1024;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;

    // One row of the line store: the sums of all four lines at one centre.
    typedef logic [NUM_LINES-1:0][HSUM_W-1:0] line_row_t;

endpackage

`default_nettype wire

[rtl/pyramid_reduce_5tap_top.sv]
// Top level of the five-tap pyramid reduction: line store, shared multiplier and sequencer.
// Usage. Grey pixels enter in raster order on the pixel channel (in_valid, in_ready,
// pixel). Each transfer is one input pixel. The block halves the image in both
// directions with a separable five-tap filter and returns interior output pixels on
// the result channel (out_valid, out_ready, out_value, out_row, out_col, frame_last).
// The zero border of the output image is never sent.
// Sequence. The block works on one pixel at a time and takes no new pixel
// until the work of the last one is done. A pixel that is not a horizontal
// centre only shifts the pixel window. A horizontal centre runs five products
// through the one shared 16 x 27 multiplier, then a drain step and a write-back
// of the line store row. A centre on an even interior row runs five more
// products for the vertical pass through the same multiplier before the drain.
// Output. A result is loaded into the output register in the write-back step,
// after the drain of its products. The output register holds the result while the
// receiver stalls; the next pixels are still taken until another result is ready,
// at which point the sequencer waits for the register to empty.
// Reset. The taps, sizes, counters and pixel window return to their reset
// values. The line store is not cleared; each entry is written before its value is used.
// Configuration writes are taken at any time and must only be issued while idle.
`default_nettype none

module pyramid_reduce_5tap_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [pr5_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pr5_pkg::CFG_DAT_W-1:0] cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [pr5_pkg::PIX_W-1:0]     pixel,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [pr5_pkg::VAL_W-1:0]          out_value,
    output logic [pr5_pkg::OROW_W-1:0]         out_row,
    output logic [pr5_pkg::OCOL_W-1:0]         out_col,
    output logic                               frame_last
);

    import pr5_pkg::*;

    // Width for the column and size comparisons, with room for a carry.
    localparam int WC_W = ((COL_W > WIDTH_W) ? COL_W : WIDTH_W) + 1;
    localparam int HC_W = HEIGHT_W + 1;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MAC    = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // Multiplier steps: the horizontal pass, then the vertical pass.
    localparam logic [3:0] STEP_H_LAST = 4'd4;
    localparam logic [3:0] STEP_V_FIRST = 4'd5;
    localparam logic [3:0] STEP_V_LAST = 4'd9;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [NUM_TAPS-1:0][TAP_W-1:0] tap_reg;
    logic [WIDTH_W-1:0]             width_reg;
    logic [HEIGHT_W-1:0]            height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg[0] <= TAP_0_RESET;
            tap_reg[1] <= TAP_1_RESET;
            tap_reg[2] <= TAP_2_RESET;
            tap_reg[3] <= TAP_3_RESET;
            tap_reg[4] <= TAP_4_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TAP_0:        tap_reg[0] <= cfg_data[TAP_W-1:0];
                REG_TAP_1:        tap_reg[1] <= cfg_data[TAP_W-1:0];
                REG_TAP_2:        tap_reg[2] <= cfg_data[TAP_W-1:0];
                REG_TAP_3:        tap_reg[3] <= cfg_data[TAP_W-1:0];
                REG_TAP_4:        tap_reg[4] <= cfg_data[TAP_W-1:0];
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Position decode for the pixel on the input channel
    // ------------------------------------------------------------------
    logic [COL_W-1:0]    col_reg;
    logic [HEIGHT_W-1:0] row_reg;
    logic [WC_W-1:0]     w_eff;
    logic [HC_W-1:0]     h_eff;
    logic [WC_W-1:0]     col_ext;
    logic [HC_W-1:0]     row_ext;
    logic                h_centre;
    logic                v_centre;
    logic [ADDR_W-1:0]   centre_idx;
    logic [OROW_W-1:0]   orow;
    logic                last_col;
    logic                last_row;
    logic                col_wrap;
    logic                row_wrap;
    logic                accept;

    always_comb
    begin
        // A zero size acts as one; a width beyond the store acts as its limit.
        if (width_reg == '0)
            w_eff = WC_W'(1);
        else if (WC_W'(width_reg) > WC_W'(MAX_WIDTH))
            w_eff = WC_W'(MAX_WIDTH);
        else
            w_eff = WC_W'(width_reg);

        if (height_reg == '0)
            h_eff = HC_W'(1);
        else
            h_eff = HC_W'(height_reg);

        col_ext = WC_W'(col_reg);
        row_ext = HC_W'(row_reg);

        // Even centres with two neighbours on each side inside the image.
        h_centre = !col_reg[0] && (col_ext >= WC_W'(4)) && (col_ext + WC_W'(2) <= w_eff);
        v_centre = !row_reg[0] && (row_ext >= HC_W'(4)) && (row_ext + HC_W'(2) <= h_eff);

        centre_idx = ADDR_W'(col_reg[COL_W-1:1]) - ADDR_W'(1);
        orow       = OROW_W'(row_reg[HEIGHT_W-1:1]) - OROW_W'(1);

        // The final interior pixel sits two centres in from the far corner.
        last_col = (WC_W'(col_reg[COL_W-1:1]) + WC_W'(1)) == (w_eff >> 1);
        last_row = (HC_W'(row_reg[HEIGHT_W-1:1]) + HC_W'(1)) == (h_eff >> 1);

        col_wrap = (col_ext + WC_W'(1)) >= w_eff;
        row_wrap = (row_ext + HC_W'(1)) >= h_eff;
    end

    // ------------------------------------------------------------------
    // Sequencer and per-pixel context
    // ------------------------------------------------------------------
    logic [1:0]                    state_reg;
    logic [1:0]                    state_next;
    logic [3:0]                    step_reg;
    logic [NUM_LINES-1:0][PIX_W-1:0] window_reg;
    logic [NUM_TAPS-1:0][PIX_W-1:0]  pix_op_reg;
    logic                          vert_reg;
    logic [1:0]                    lane_reg;
    logic [ADDR_W-1:0]             idx_reg;
    logic [OROW_W-1:0]             orow_reg;
    logic                          last_reg;
    logic                          out_free;
    logic                          finish_done;

    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_free    = !out_valid || out_ready;
    assign finish_done = !vert_reg || out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && h_centre)
                    state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if ((vert_reg && step_reg == STEP_V_LAST) ||
                    (!vert_reg && step_reg == STEP_H_LAST))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (finish_done)
                    state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            window_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MAC)
                step_reg <= step_reg + 4'd1;
            else
                step_reg <= '0;

            if (accept)
            begin
                window_reg <= {pixel, window_reg[NUM_LINES-1:1]};
                if (col_wrap)
                begin
                    col_reg <= '0;
                    row_reg <= row_wrap ? '0 : row_reg + HEIGHT_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    // Context of the accepted pixel, held for the length of its work.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_op_reg <= {pixel, window_reg};
            vert_reg   <= v_centre;
            lane_reg   <= row_reg[1:0];
            idx_reg    <= centre_idx;
            orow_reg   <= orow;
            last_reg   <= last_col && last_row;
        end
    end

    // ------------------------------------------------------------------
    // Line store: one row holds the four lines at one centre. The row is read
    // when the pixel is taken, and written back with this line's sum replaced.
    // ------------------------------------------------------------------
    line_row_t mem [HALF_W];
    line_row_t rd_row_reg;
    line_row_t wr_row;
    logic signed [HSUM_W-1:0] hacc_reg;

    always_comb
    begin
        wr_row           = rd_row_reg;
        wr_row[lane_reg] = hacc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept && h_centre)
            rd_row_reg <= mem[centre_idx];
        if (state_reg == ST_FINISH)
            mem[idx_reg] <= wr_row;
    end

    // ------------------------------------------------------------------
    // Shared multiplier with a registered product, then accumulation
    // ------------------------------------------------------------------
    logic [2:0]               tap_sel;
    logic [1:0]               line_sel;
    logic signed [TAP_W-1:0]  mul_a;
    logic signed [HSUM_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_full;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic                     prod_vert_reg;
    logic signed [VACC_W-1:0] vacc_reg;

    always_comb
    begin
        line_sel = 2'(step_reg - STEP_V_FIRST) + lane_reg;
        if (step_reg < STEP_V_FIRST)
        begin
            tap_sel = 3'(step_reg);
            mul_b   = $signed(HSUM_W'(pix_op_reg[tap_sel]));
        end
        else if (step_reg == STEP_V_LAST)
        begin
            // The newest row comes from the sum just formed, not the store.
            tap_sel = 3'(NUM_TAPS - 1);
            mul_b   = hacc_reg;
        end
        else
        begin
            tap_sel = 3'(step_reg - STEP_V_FIRST);
            mul_b   = $signed(rd_row_reg[line_sel]);
        end
        mul_a = $signed(tap_reg[tap_sel]);
    end

    // Both operands are signed, so the full product is formed at its own width.
    assign prod_full = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= (state_reg == ST_MAC);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_full;
        prod_vert_reg <= (step_reg >= STEP_V_FIRST);
        if (accept)
        begin
            hacc_reg <= '0;
            vacc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            if (prod_vert_reg)
                vacc_reg <= vacc_reg + VACC_W'(prod_reg);
            else
                hacc_reg <= hacc_reg + prod_reg[HSUM_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Scaling, clamping and the output register
    // ------------------------------------------------------------------
    logic [VACC_W-VSCALE-1:0] quot;
    logic [VAL_W-1:0]         result_val;
    logic                     out_valid_reg;
    logic [VAL_W-1:0]         out_value_reg;
    logic [OROW_W-1:0]        out_row_reg;
    logic [OCOL_W-1:0]        out_col_reg;
    logic                     frame_last_reg;
    logic                     load_out;

    always_comb
    begin
        quot = vacc_reg[VACC_W-1:VSCALE];
        if (vacc_reg[VACC_W-1] || vacc_reg == '0)
            result_val = '0;
        else if (quot > (VACC_W-VSCALE)'(255))
            result_val = '1;
        else
            result_val = quot[VAL_W-1:0];
    end

    assign load_out = (state_reg == ST_FINISH) && vert_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_value_reg  <= result_val;
            out_row_reg    <= orow_reg;
            out_col_reg    <= OCOL_W'(idx_reg);
            frame_last_reg <= last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign frame_last = frame_last_reg;

endmodule

`default_nettype wire

[rtl/pr5_checker.sv]
// Port-level assertions for the pyramid reduction top level, with their bind.
`default_nettype none

module pr5_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [pr5_pkg::VAL_W-1:0]     out_value,
    input wire logic [pr5_pkg::OROW_W-1:0]    out_row,
    input wire logic [pr5_pkg::OCOL_W-1:0]    out_col,
    input wire logic                          frame_last
);

    import pr5_pkg::*;

    // A clock edge in reset leaves the output register empty.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result offered during reset");

    // The zero border is never sent: no result has a row or column of zero.
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_row != '0) && (out_col != '0))
        else $error("border pixel sent");

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its contents.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_value) && $stable(out_row) &&
        $stable(out_col) && $stable(frame_last))
        else $error("result changed while stalled");

endmodule

bind pyramid_reduce_5tap_top pr5_checker u_pr5_checker (.*);

`default_nettype wire
